### rtl/core/spherical_to_cartesian_projection_defines.svh
// ----------------------------------------------------------------------------
// Spherical to Cartesian projection: assertion macros
// Shared concurrent check forms used by the projection block.
// ----------------------------------------------------------------------------
`ifndef SPHERICAL_TO_CARTESIAN_PROJECTION_DEFINES_SVH
`define SPHERICAL_TO_CARTESIAN_PROJECTION_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define S2C_CHECK_NOW(lbl, ck, rstn, ante, cons, msg) \
	lbl: assert property (@(posedge ck) disable iff (!rstn) (ante) |-> (cons)) \
		else $error(msg);

// Implication with a fixed delay, disabled while reset is asserted.
`define S2C_CHECK_AFTER(lbl, ck, rstn, ante, cons, dly, msg) \
	lbl: assert property (@(posedge ck) disable iff (!rstn) (ante) |-> ##dly (cons)) \
		else $error(msg);

`endif

### rtl/core/s2c_pkg.sv
// ----------------------------------------------------------------------------
// s2c_pkg
// Types, constants and arithmetic helpers of the spherical projection block.
// ----------------------------------------------------------------------------
package s2c_pkg;

	localparam int ANGLE_BITS     = 16;
	localparam int TRIG_FRAC_BITS = 15;
	localparam int TRIG_W         = TRIG_FRAC_BITS + 1;
	localparam int TRIG_SH        = 30 - TRIG_FRAC_BITS;
	localparam int SERIES_TERMS   = 8;
	localparam int PROD_W         = 32 + TRIG_W;

	localparam int LANE_SIN = 0;
	localparam int LANE_COS = 1;

	// Angle to radians conversion, split so that only a small divide remains.
	localparam logic [31:0] PI_Q30      = 32'd3373259426;
	localparam logic [31:0] HALF_PI_Q30 = 32'd1686629713;
	localparam logic [31:0] ONE_Q30     = 32'h4000_0000;
	localparam logic [31:0] HALF_RANGE  = 32'((64'd1 << (ANGLE_BITS - 1)) - 64'd1);
	localparam logic [31:0] FOLD_QUO    = PI_Q30 / HALF_RANGE;
	localparam logic [31:0] FOLD_REM    = PI_Q30 % HALF_RANGE;
	localparam logic [31:0] ROUND_ADD   = HALF_RANGE / 2;
	localparam int          RECIP_SH    = 31;
	localparam logic [31:0] FOLD_RECIP  = 32'((64'd1 << RECIP_SH) / 64'(HALF_RANGE));

	// Series divisors and their reciprocals, sine lane first.
	localparam int DIV_SH = 34;
	localparam logic [8:0] SER_DIV [2][SERIES_TERMS] = '{
		'{9'd6, 9'd20, 9'd42, 9'd72, 9'd110, 9'd156, 9'd210, 9'd272},
		'{9'd2, 9'd12, 9'd30, 9'd56, 9'd90, 9'd132, 9'd182, 9'd240}
	};
	localparam logic [33:0] SER_RECIP [2][SERIES_TERMS] = '{
		'{34'((64'd1 << DIV_SH) / 64'd6),   34'((64'd1 << DIV_SH) / 64'd20),
		  34'((64'd1 << DIV_SH) / 64'd42),  34'((64'd1 << DIV_SH) / 64'd72),
		  34'((64'd1 << DIV_SH) / 64'd110), 34'((64'd1 << DIV_SH) / 64'd156),
		  34'((64'd1 << DIV_SH) / 64'd210), 34'((64'd1 << DIV_SH) / 64'd272)},
		'{34'((64'd1 << DIV_SH) / 64'd2),   34'((64'd1 << DIV_SH) / 64'd12),
		  34'((64'd1 << DIV_SH) / 64'd30),  34'((64'd1 << DIV_SH) / 64'd56),
		  34'((64'd1 << DIV_SH) / 64'd90),  34'((64'd1 << DIV_SH) / 64'd132),
		  34'((64'd1 << DIV_SH) / 64'd182), 34'((64'd1 << DIV_SH) / 64'd240)}
	};

	localparam int TRIG_LAT  = 5 + 3 * SERIES_TERMS + 1;
	localparam int SCALE_LAT = 4;
	localparam int TOTAL_LAT = TRIG_LAT + SCALE_LAT;

	typedef logic signed [TRIG_W-1:0] trig_t;
	typedef logic signed [31:0]       q16_t;
	typedef logic signed [PROD_W-1:0] prod_t;

	typedef struct packed {
		logic  valid;
		trig_t sin_v;
		trig_t cos_v;
	} trig_beat_t;

	typedef struct packed {
		logic               sign;
		logic [31:0]        mag;
		logic signed [33:0] sum;
	} lane_t;

	// Fixes a reciprocal quotient estimate that is at most one short.
	function automatic logic [32:0] div_fix(input logic [32:0] n, input logic [32:0] qe,
			input logic [8:0] d);
		logic [32:0] rem;
		rem = n - 33'(qe * 33'(d));
		div_fix = (rem >= 33'(d)) ? qe + 33'd1 : qe;
	endfunction

	// Q2.30 sum to Q1.TRIG_FRAC_BITS, round half away from zero, saturate.
	function automatic trig_t to_trig(input logic signed [33:0] s);
		logic [33:0]        mag;
		logic [33:0]        rm;
		logic signed [34:0] v;
		mag = s[33] ? 34'(-s) : 34'(s);
		rm  = (mag + (34'd1 << (TRIG_SH - 1))) >> TRIG_SH;
		v   = s[33] ? -$signed({1'b0, rm}) : $signed({1'b0, rm});
		if ((&v[34:TRIG_FRAC_BITS]) | ~(|v[34:TRIG_FRAC_BITS]))
			to_trig = v[TRIG_W-1:0];
		else if (v[34])
			to_trig = {1'b1, {TRIG_FRAC_BITS{1'b0}}};
		else
			to_trig = {1'b0, {TRIG_FRAC_BITS{1'b1}}};
	endfunction

	// Product back to Q16.16, round half away from zero, saturate to 32 bits.
	function automatic q16_t rnd_sat(input prod_t p);
		logic [PROD_W-1:0]   mag;
		logic [PROD_W-1:0]   rm;
		logic signed [PROD_W:0] v;
		mag = p[PROD_W-1] ? PROD_W'(-p) : PROD_W'(p);
		rm  = (mag + (PROD_W'(1) << (TRIG_FRAC_BITS - 1))) >> TRIG_FRAC_BITS;
		v   = p[PROD_W-1] ? -$signed({1'b0, rm}) : $signed({1'b0, rm});
		if ((&v[PROD_W:31]) | ~(|v[PROD_W:31]))
			rnd_sat = v[31:0];
		else if (v[PROD_W])
			rnd_sat = 32'sh8000_0000;
		else
			rnd_sat = 32'sh7FFF_FFFF;
	endfunction

	function automatic q16_t neg_sat(input q16_t v);
		neg_sat = (v == 32'sh8000_0000) ? 32'sh7FFF_FFFF : -v;
	endfunction

endpackage

### rtl/core/s2c_trig.sv
// ----------------------------------------------------------------------------
// s2c_trig
// Pipelined sine and cosine of one half-turn angle, Q1.15 out.
// ----------------------------------------------------------------------------
module s2c_trig (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             in_valid,
	input  logic [s2c_pkg::ANGLE_BITS-1:0]   angle,
	output s2c_pkg::trig_beat_t              out_beat
);
	import s2c_pkg::*;

	typedef struct packed {
		logic        neg;
		logic        folded;
		logic [31:0] x2;
	} ctl_t;

	logic                  neg_in;
	logic [ANGLE_BITS-1:0] mag_in;

	logic vld_s1, vld_s2, vld_s3, vld_s4, vld_s5;
	logic neg_s1, neg_s2, neg_s3, neg_s4;
	logic [31:0] p1_s1, n_s1, p1_s2, n_s2, qe_s2, rem_s2, theta_s3;
	logic        folded_c, folded_s4;
	logic signed [32:0] t_s4;
	logic [31:0] tmag_c;
	ctl_t  ctl_s5;
	lane_t lane_s5 [2];

	logic [SERIES_TERMS-1:0] vld_in, vld_s6, vld_s7, vld_s8;
	ctl_t  ctl_in  [SERIES_TERMS];
	ctl_t  ctl_s6  [SERIES_TERMS];
	ctl_t  ctl_s7  [SERIES_TERMS];
	ctl_t  ctl_s8  [SERIES_TERMS];
	lane_t lane_in [SERIES_TERMS][2];
	lane_t lane_s6 [SERIES_TERMS][2];
	lane_t lane_s7 [SERIES_TERMS][2];
	lane_t lane_s8 [SERIES_TERMS][2];
	logic [32:0] n_s6  [SERIES_TERMS][2];
	logic [32:0] n_s7  [SERIES_TERMS][2];
	logic [32:0] qe_s7 [SERIES_TERMS][2];
	logic [32:0] q_c   [SERIES_TERMS][2];

	logic signed [33:0] sin_sum_c, cos_sum_c;
	logic  vld_s30;
	trig_t sin_s30, cos_s30;

	assign neg_in = angle[ANGLE_BITS-1];
	assign mag_in = neg_in ? (~angle + 1'b1) : angle;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
		end else begin
			vld_s1 <= in_valid;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
			vld_s5 <= vld_s4;
		end
	end

	// Stages one to three: theta = round(mag * pi / HALF_RANGE) in Q2.30.
	assign rem_s2   = n_s2 - 32'(64'(qe_s2) * 64'(HALF_RANGE));
	assign folded_c = theta_s3 > HALF_PI_Q30;
	assign tmag_c   = t_s4[32] ? 32'(-t_s4) : t_s4[31:0];

	always_ff @(posedge clk) begin
		neg_s1   <= neg_in;
		p1_s1    <= 32'(64'(mag_in) * 64'(FOLD_QUO));
		n_s1     <= 32'(64'(mag_in) * 64'(FOLD_REM) + 64'(ROUND_ADD));
		neg_s2   <= neg_s1;
		p1_s2    <= p1_s1;
		n_s2     <= n_s1;
		qe_s2    <= 32'((64'(n_s1) * 64'(FOLD_RECIP)) >> RECIP_SH);
		neg_s3   <= neg_s2;
		theta_s3 <= p1_s2 + qe_s2 + ((rem_s2 >= HALF_RANGE) ? 32'd1 : 32'd0);
		neg_s4    <= neg_s3;
		folded_s4 <= folded_c;
		t_s4      <= folded_c ? $signed({1'b0, PI_Q30}) - $signed({1'b0, theta_s3})
				: $signed({1'b0, theta_s3});
		ctl_s5.neg    <= neg_s4;
		ctl_s5.folded <= folded_s4;
		ctl_s5.x2     <= 32'((64'(tmag_c) * 64'(tmag_c)) >> 30);
		lane_s5[LANE_SIN].sign <= t_s4[32];
		lane_s5[LANE_SIN].mag  <= tmag_c;
		lane_s5[LANE_SIN].sum  <= 34'(t_s4);
		lane_s5[LANE_COS].sign <= 1'b0;
		lane_s5[LANE_COS].mag  <= ONE_Q30;
		lane_s5[LANE_COS].sum  <= 34'(ONE_Q30);
	end

	// One series term per three stages: multiply, reciprocal, correct and add.
	for (genvar k = 0; k < SERIES_TERMS; k++) begin : g_term
		if (k == 0) begin : g_first
			assign vld_in[k]     = vld_s5;
			assign ctl_in[k]     = ctl_s5;
			assign lane_in[k][0] = lane_s5[0];
			assign lane_in[k][1] = lane_s5[1];
		end else begin : g_next
			assign vld_in[k]     = vld_s8[k-1];
			assign ctl_in[k]     = ctl_s8[k-1];
			assign lane_in[k][0] = lane_s8[k-1][0];
			assign lane_in[k][1] = lane_s8[k-1][1];
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s6[k] <= 1'b0;
				vld_s7[k] <= 1'b0;
				vld_s8[k] <= 1'b0;
			end else begin
				vld_s6[k] <= vld_in[k];
				vld_s7[k] <= vld_s6[k];
				vld_s8[k] <= vld_s7[k];
			end
		end

		always_comb begin
			for (int l = 0; l < 2; l++)
				q_c[k][l] = div_fix(n_s7[k][l], qe_s7[k][l], SER_DIV[l][k]);
		end

		always_ff @(posedge clk) begin
			ctl_s6[k] <= ctl_in[k];
			ctl_s7[k] <= ctl_s6[k];
			ctl_s8[k] <= ctl_s7[k];
			for (int l = 0; l < 2; l++) begin
				n_s6[k][l]    <= 33'((64'(lane_in[k][l].mag) * 64'(ctl_in[k].x2)) >> 30);
				lane_s6[k][l] <= lane_in[k][l];
				n_s7[k][l]    <= n_s6[k][l];
				qe_s7[k][l]   <= 33'((67'(n_s6[k][l]) * 67'(SER_RECIP[l][k])) >> DIV_SH);
				lane_s7[k][l] <= lane_s6[k][l];
				lane_s8[k][l].sign <= ~lane_s7[k][l].sign;
				lane_s8[k][l].mag  <= q_c[k][l][31:0];
				lane_s8[k][l].sum  <= lane_s7[k][l].sum + (lane_s7[k][l].sign
						? 34'(q_c[k][l]) : -34'(q_c[k][l]));
			end
		end
	end

	// Final stage: apply the angle sign and fold, then round to Q1.15.
	assign sin_sum_c = ctl_s8[SERIES_TERMS-1].neg ? -lane_s8[SERIES_TERMS-1][LANE_SIN].sum
			: lane_s8[SERIES_TERMS-1][LANE_SIN].sum;
	assign cos_sum_c = ctl_s8[SERIES_TERMS-1].folded
			? -lane_s8[SERIES_TERMS-1][LANE_COS].sum
			: lane_s8[SERIES_TERMS-1][LANE_COS].sum;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s30 <= 1'b0;
		end else begin
			vld_s30 <= vld_s8[SERIES_TERMS-1];
		end
	end

	always_ff @(posedge clk) begin
		sin_s30 <= to_trig(sin_sum_c);
		cos_s30 <= to_trig(cos_sum_c);
	end

	assign out_beat = '{valid: vld_s30, sin_v: sin_s30, cos_v: cos_s30};

endmodule

### rtl/core/s2c_scale.sv
// ----------------------------------------------------------------------------
// s2c_scale
// Scales sine and cosine by the radius and forms the three coordinates.
// ----------------------------------------------------------------------------
module s2c_scale (
	input  logic                clk,
	input  logic                arst_n,
	input  s2c_pkg::trig_beat_t beat_a,
	input  s2c_pkg::trig_beat_t beat_b,
	input  s2c_pkg::q16_t       radius,
	output logic                done,
	output s2c_pkg::q16_t       pos_x,
	output s2c_pkg::q16_t       pos_y,
	output s2c_pkg::q16_t       pos_z
);
	import s2c_pkg::*;

	logic  vld_s1, vld_s2, vld_s3;
	prod_t px_prod_s1, rc_prod_s1, py_prod_s3, pz_prod_s3;
	trig_t sb_s1, cb_s1, sb_s2, cb_s2;
	q16_t  px_s2, rc_s2, px_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			done   <= 1'b0;
		end else begin
			vld_s1 <= beat_a.valid;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			done   <= vld_s3;
		end
	end

	// radius*cos(a) is rounded and saturated before the second factor.
	always_ff @(posedge clk) begin
		px_prod_s1 <= prod_t'(radius) * prod_t'(beat_a.sin_v);
		rc_prod_s1 <= prod_t'(radius) * prod_t'(beat_a.cos_v);
		sb_s1      <= beat_b.sin_v;
		cb_s1      <= beat_b.cos_v;
		px_s2      <= rnd_sat(px_prod_s1);
		rc_s2      <= rnd_sat(rc_prod_s1);
		sb_s2      <= sb_s1;
		cb_s2      <= cb_s1;
		px_s3      <= px_s2;
		py_prod_s3 <= prod_t'(rc_s2) * prod_t'(cb_s2);
		pz_prod_s3 <= prod_t'(rc_s2) * prod_t'(sb_s2);
		pos_x      <= px_s3;
		pos_y      <= rnd_sat(py_prod_s3);
		pos_z      <= neg_sat(rnd_sat(pz_prod_s3));
	end

endmodule

### rtl/core/spherical_to_cartesian_projection.sv
// ----------------------------------------------------------------------------
// spherical_to_cartesian_projection
// Two half-turn angles and a Q16.16 radius to x, y, z in Q16.16.
// ----------------------------------------------------------------------------
// Usage: drive angle_first, angle_second and radius and raise start for one
// cycle per beat. A beat is taken at every rising edge where start is high
// and busy is low. The pipeline never stalls, so busy stays low and a new
// beat may be offered in every cycle; throughput is one beat per clock.
// The result beat for an input is on pos_x, pos_y and pos_z, with done high,
// once it has passed the trig pipeline (30 stages: five to turn the angle
// into folded radians, three per series term for eight terms, and one to
// round to Q1.15) and then four stages of scaling multiplies.
// done is high for exactly one cycle per result and the receiver cannot hold
// results off; a result that is not taken in its cycle is gone.
// Asynchronous reset clears every valid bit, so no stale beat can appear
// after reset; data registers are not reset.
// ----------------------------------------------------------------------------
`include "spherical_to_cartesian_projection_defines.svh"

module spherical_to_cartesian_projection (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	output logic                busy,
	input  logic signed [15:0]  angle_first,
	input  logic signed [15:0]  angle_second,
	input  logic signed [31:0]  radius,
	output logic                done,
	output logic signed [31:0]  pos_x,
	output logic signed [31:0]  pos_y,
	output logic signed [31:0]  pos_z
);
	import s2c_pkg::*;

	logic       accept;
	trig_beat_t trig_a, trig_b;
	q16_t       radius_dly_q [TRIG_LAT];

	// The pipeline has no back pressure, so every offered beat is taken.
	assign busy   = 1'b0;
	assign accept = start & ~busy;

	// Elevation and azimuth each get their own trig pipeline; both run in
	// lockstep, so their valid bits match every cycle.
	s2c_trig u_trig_a (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (accept),
		.angle    (angle_first[ANGLE_BITS-1:0]),
		.out_beat (trig_a)
	);

	s2c_trig u_trig_b (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (accept),
		.angle    (angle_second[ANGLE_BITS-1:0]),
		.out_beat (trig_b)
	);

	// Radius rides alongside the trig pipelines so that it meets sine and
	// cosine of the same beat.
	always_ff @(posedge clk) begin
		radius_dly_q[0] <= radius;
		for (int i = 1; i < TRIG_LAT; i++)
			radius_dly_q[i] <= radius_dly_q[i-1];
	end

	s2c_scale u_scale (
		.clk    (clk),
		.arst_n (arst_n),
		.beat_a (trig_a),
		.beat_b (trig_b),
		.radius (radius_dly_q[TRIG_LAT-1]),
		.done   (done),
		.pos_x  (pos_x),
		.pos_y  (pos_y),
		.pos_z  (pos_z)
	);

	`S2C_CHECK_NOW(a_lanes_aligned, clk, arst_n, 1'b1, trig_a.valid == trig_b.valid, "trig pipelines out of step")
	`S2C_CHECK_AFTER(a_beat_delivered, clk, arst_n, accept, done, TOTAL_LAT, "accepted beat not delivered on time")
	`S2C_CHECK_NOW(a_no_invented_beat, clk, arst_n, done, $past(accept, TOTAL_LAT), "result beat without an input beat")

endmodule

### dv/tb_top.sv
// ----------------------------------------------------------------------------
// Spherical to Cartesian projection testbench
// Drives angle and radius beats with random gaps, predicts x, y and z with a
// fixed-point sine/cosine series of its own, and checks every result beat.
// ----------------------------------------------------------------------------
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	import s2c_pkg::*;

	localparam int   LATENCY_CYCLES = 34;
	localparam int   CYCLE_LIMIT    = 400000;
	localparam longint PI_FIX       = 64'd3373259426;
	localparam longint HALF_PI_FIX  = 64'd1686629713;
	localparam longint ONE_FIX      = 64'd1073741824;

	// Expected coordinates for one beat.
	typedef struct {
		logic signed [31:0] x;
		logic signed [31:0] y;
		logic signed [31:0] z;
	} coord_t;

	logic               clk;
	logic               arst_n;
	logic               start;
	logic               busy;
	logic signed [15:0] angle_first;
	logic signed [15:0] angle_second;
	logic signed [31:0] radius;
	logic               done;
	logic signed [31:0] pos_x;
	logic signed [31:0] pos_y;
	logic signed [31:0] pos_z;

	coord_t pending_coords[$];
	int     error_count;
	int     cycle_count;

	spherical_to_cartesian_projection i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.angle_first  (angle_first),
		.angle_second (angle_second),
		.radius       (radius),
		.done         (done),
		.pos_x        (pos_x),
		.pos_y        (pos_y),
		.pos_z        (pos_z)
	);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	// Rounds a value right by sh bits, ties away from zero.
	function automatic longint shift_round(input longint v, input int sh);
		longint mag;
		mag = (v < 0) ? -v : v;
		mag = (mag + (64'sd1 <<< (sh - 1))) >>> sh;
		return (v < 0) ? -mag : mag;
	endfunction

	function automatic longint clip32(input longint v);
		if (v > 64'sd2147483647)
			return 64'sd2147483647;
		if (v < -64'sd2147483648)
			return -64'sd2147483648;
		return v;
	endfunction

	// Taylor series in Q2.30; every term is truncated toward zero, as the
	// signed divide does.
	function automatic longint taylor_q30(input longint t, input bit want_sine);
		longint mag_t;
		longint t_sq;
		longint term;
		longint sum;
		longint div;
		mag_t = (t < 0) ? -t : t;
		t_sq  = (mag_t * mag_t) >>> 30;
		term  = want_sine ? t : ONE_FIX;
		sum   = term;
		for (int k = 1; k <= 8; k++) begin
			div  = want_sine ? (2 * k) * (2 * k + 1) : (2 * k - 1) * (2 * k);
			term = -((term * t_sq) / (div * ONE_FIX));
			sum += term;
		end
		return sum;
	endfunction

	function automatic longint q30_to_q15(input longint v);
		longint r;
		r = shift_round(v, 30 - TRIG_FRAC_BITS);
		if (r > (64'sd1 <<< TRIG_FRAC_BITS) - 1)
			r = (64'sd1 <<< TRIG_FRAC_BITS) - 1;
		if (r < -(64'sd1 <<< TRIG_FRAC_BITS))
			r = -(64'sd1 <<< TRIG_FRAC_BITS);
		return r;
	endfunction

	// Sine and cosine of a half-turn angle in Q1.15. The magnitude is folded
	// about pi/2, the cosine negated after a fold and the sine after a
	// negative angle.
	function automatic void angle_sin_cos(input logic signed [15:0] ang, output longint s,
			output longint c);
		longint mag;
		longint theta;
		longint t;
		longint sv;
		longint cv;
		bit     folded;
		mag    = (ang < 0) ? -longint'(ang) : longint'(ang);
		theta  = (mag * PI_FIX + 64'd16383) / 64'd32767;
		folded = theta > HALF_PI_FIX;
		t      = folded ? PI_FIX - theta : theta;
		sv     = taylor_q30(t, 1'b1);
		cv     = taylor_q30(t, 1'b0);
		if (folded)
			cv = -cv;
		if (ang < 0)
			sv = -sv;
		s = q30_to_q15(sv);
		c = q30_to_q15(cv);
	endfunction

	function automatic longint scale_q15(input longint a, input longint trig);
		return clip32(shift_round(a * trig, TRIG_FRAC_BITS));
	endfunction

	function automatic coord_t project_point(input logic signed [15:0] elev,
			input logic signed [15:0] azim, input logic signed [31:0] rad);
		coord_t p;
		longint sa, ca, sb, cb, rc;
		angle_sin_cos(elev, sa, ca);
		angle_sin_cos(azim, sb, cb);
		rc  = scale_q15(rad, ca);
		p.x = 32'(scale_q15(rad, sa));
		p.y = 32'(scale_q15(rc, cb));
		p.z = 32'(clip32(-scale_q15(rc, sb)));
		return p;
	endfunction

	// Offers one beat, holds start until it is taken, then idles for the given
	// gap. With no gap start stays high into the next beat.
	task automatic send_beat(input logic signed [15:0] elev, input logic signed [15:0] azim,
			input logic signed [31:0] rad, input int gap);
		start        <= 1'b1;
		angle_first  <= elev;
		angle_second <= azim;
		radius       <= rad;
		do
			@(posedge clk);
		while (busy);
		pending_coords.push_back(project_point(elev, azim, rad));
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// Mostly back to back or short gaps, now and then a long one.
	function automatic int pick_gap();
		int roll;
		roll = $urandom_range(0, 99);
		if (roll < 50)
			return 0;
		if (roll < 92)
			return $urandom_range(1, 3);
		return $urandom_range(10, 60);
	endfunction

	function automatic logic signed [31:0] pick_radius();
		case ($urandom_range(0, 5))
			0: return 32'($urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000);
			1: return 32'($urandom_range(0, 1) ? 32'h0001_0000 : 32'hFFFF_0000);
			2: return 32'($urandom_range(0, 200)) - 32'sd100;
			default: return 32'($urandom);
		endcase
	endfunction

	function automatic logic signed [15:0] pick_angle();
		case ($urandom_range(0, 7))
			0: return 16'($urandom_range(0, 1) ? 16'h7FFF : 16'h8000);
			// Near the fold at a quarter turn.
			1: return 16'($urandom_range(0, 1) ? int'($urandom_range(16380, 16388))
					: -int'($urandom_range(16380, 16388)));
			2: return 16'($urandom_range(0, 8)) - 16'sd4;
			default: return 16'($urandom);
		endcase
	endfunction

	// Stops the sender until every expected result has come back.
	task automatic drain_results();
		start <= 1'b0;
		@(posedge clk);
		while (pending_coords.size() != 0)
			@(posedge clk);
	endtask

	// Field extremes, the zero angle, the quarter-turn fold, the most
	// negative angle and saturating radii.
	task automatic test_directed();
		logic signed [15:0] angles[9];
		logic signed [31:0] radii[3];
		angles = '{16'sh0000, 16'sh7FFF, -16'sh7FFF, 16'sh8000, 16'sd16383, 16'sd16384,
			-16'sd16384, 16'sd1, -16'sd1};
		radii  = '{32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh0001_0000};
		foreach (angles[i])
			send_beat(angles[i], angles[8 - i], radii[i % 3], i % 2);
		send_beat(16'sh0000, 16'sh8000, 32'sh8000_0000, 0);
		send_beat(16'sh8000, 16'sh0000, 32'sh7FFF_FFFF, 0);
		send_beat(16'sh5555, 16'shAAAA, 32'sh5555_5555, 2);
		send_beat(16'shAAAA, 16'sh5555, 32'shAAAA_AAAA, 0);
		send_beat(16'sh0000, 16'sh0000, 32'sh0000_0000, 0);
		drain_results();
	endtask

	task automatic test_random(input int beats);
		for (int i = 0; i < beats; i++) begin
			send_beat(pick_angle(), pick_angle(), pick_radius(), pick_gap());
			if (i == beats / 2)
				drain_results();
		end
	endtask

	// Result checker: a done beat is compared with the oldest expectation.
	always @(posedge clk) begin
		coord_t want;
		if (arst_n && done) begin
			if (pending_coords.size() == 0) begin
				$error("result beat with nothing expected");
				error_count++;
			end else begin
				want = pending_coords.pop_front();
				if (pos_x !== want.x) begin
					$error("pos_x expected %0d actual %0d", want.x, pos_x);
					error_count++;
				end
				if (pos_y !== want.y) begin
					$error("pos_y expected %0d actual %0d", want.y, pos_y);
					error_count++;
				end
				if (pos_z !== want.z) begin
					$error("pos_z expected %0d actual %0d", want.z, pos_z);
					error_count++;
				end
			end
		end
	end

	// Watchdog on the whole run.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("DONE: errors detected");
			$finish;
		end
	end

	initial begin
		error_count  = 0;
		cycle_count  = 0;
		arst_n       = 1'b0;
		start        = 1'b0;
		angle_first  = '0;
		angle_second = '0;
		radius       = '0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed();
		test_random(1080);

		drain_results();
		repeat (LATENCY_CYCLES + 10) @(posedge clk);
		if (error_count == 0 && pending_coords.size() == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end
endmodule
